/* rtl/cd_text_pack_framer_unit_assert.svh */
// ----------------------------------------------------------------------------
// cd_text_pack_framer_unit assertion macros
// concurrent assertion wrappers, removed when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef CD_TEXT_PACK_FRAMER_UNIT_ASSERT_SVH
`define CD_TEXT_PACK_FRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// invariant checked at every clock edge out of reset
`define CDTPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define CDTPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CDTPF_ASSERT(lbl, prop, msg)
`define CDTPF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/cdtpf_pkg.sv */
// ----------------------------------------------------------------------------
// cdtpf_pkg
// shared types, constants and the pack crc for the cd-text pack framer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdtpf_pkg;

  // payload bytes per pack
  localparam int unsigned PAYLOAD_BYTES = 12;
  localparam int unsigned FILL_W        = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned HALF_BYTES    = PAYLOAD_BYTES / 2;
  localparam int unsigned HALF_W        = 8 * HALF_BYTES;

  // crc-16 generator, ccitt polynomial, zero preset
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // header type base
  localparam logic [3:0] TYPE_BASE = 4'h8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK = 1'b1;

  // stream widths
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned S_USER_W = 7;
  localparam int unsigned M_DATA_W = 144;
  localparam int unsigned CFG_W    = 3;

  // header and payload of a finished pack
  typedef struct packed {
    logic [7:0]        ptype;
    logic [6:0]        track;
    logic [7:0]        seq;
    logic [7:0]        blk_pos;
    logic [HALF_W-1:0] pay_hi;
    logic [HALF_W-1:0] pay_lo;
  } pack_t;

  // crc over header and payload, first byte first, msb first
  function automatic logic [15:0] pack_crc(input pack_t pk);
    logic [127:0] msg;
    logic [15:0]  crc;
    logic         fb;
    msg = {pk.ptype, 1'b0, pk.track, pk.seq, pk.blk_pos, pk.pay_hi, pk.pay_lo};
    crc = CRC_INIT;
    for (int i = 127; i >= 0; i--) begin
      fb  = crc[15] ^ msg[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* rtl/cd_text_pack_framer_unit.sv */
// ----------------------------------------------------------------------------
// cd_text_pack_framer_unit
// packs cd-text field bytes into 12-byte packs with header and crc-16
// ----------------------------------------------------------------------------
// Text bytes arrive one per transaction on the s_axis channel; tlast marks
// the last byte of a field, after which one or two zero terminators are
// appended. tuser carries has_byte, type_code, flush and new_block. Finished
// packs leave on m_axis, one transaction per pack, header, payload and crc
// packed into tdata. Configuration (terminator count, block number) is
// written on the cfg channel, which is always ready.
// An input transaction is taken every cycle while the output side drains.
// The pack state updates in the accepting cycle and a completed pack is
// held in a pack register; the crc is then computed over 128 bits and
// captured in the output register, which drives m_axis. Two stages
// decouple the sides: when m_axis stalls the pack register fills and
// s_axis_tready drops only once a second pack is waiting. Reset closes any
// open pack, clears the sequence and position counters, and sets one
// terminator and block zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cd_text_pack_framer_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // input byte stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] data_byte, [14:8] track_number
  input  wire  [cdtpf_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  wire                             s_axis_tlast,
  // [0] has_byte, [4:1] type_code, [5] flush, [6] new_block
  input  wire  [cdtpf_pkg::S_USER_W-1:0]  s_axis_tuser,
  // output packs
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // [7:0] pack_type, [14:8] pack_track, [22:15] sequence_res,
  // [30:23] block_and_position, [78:31] payload_high,
  // [126:79] payload_low, [142:127] check_word
  output logic [cdtpf_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // configuration writes
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [cdtpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [cdtpf_pkg::CFG_W-1:0]     cfg_data_i
);

  import cdtpf_pkg::*;

  `include "cd_text_pack_framer_unit_assert.svh"

  // input fields
  logic [7:0] in_data;
  logic [6:0] in_track;
  logic [3:0] in_type;
  logic       in_has;
  logic       in_eof;
  logic       in_flush;
  logic       in_nb;

  assign in_data  = s_axis_tdata[7:0];
  assign in_track = s_axis_tdata[14:8];
  assign in_eof   = s_axis_tlast;
  assign in_has   = s_axis_tuser[0];
  assign in_type  = s_axis_tuser[4:1];
  assign in_flush = s_axis_tuser[5];
  assign in_nb    = s_axis_tuser[6];

  // configuration registers
  logic [1:0] term_q;
  logic [2:0] blk_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= 2'd1;
      blk_q  <= 3'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TERM:  term_q <= cfg_data_i[1:0];
        CFG_BLOCK: blk_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // pack state
  logic [7:0]        store_q [PAYLOAD_BYTES];
  logic [7:0]        store_d [PAYLOAD_BYTES];
  logic [7:0]        cur_store [PAYLOAD_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d, fill_eff;
  logic              open_q, open_d;
  logic [7:0]        type_q, type_d, cur_type;
  logic [6:0]        track_q, track_d, cur_track;
  logic [3:0]        pos_q, pos_d, cur_pos;
  logic [7:0]        seq_q, seq_d, seq_base;
  logic [3:0]        fpos_q, fpos_d;
  logic [1:0]        terms, nbytes;
  logic [FILL_W:0]   fill_sum;
  logic [FILL_W-1:0] left;
  logic              emit;
  pack_t             pk_d;

  // handshake between stages
  logic  s_fire, pk_ready, out_ready;
  logic  pv_q, mv_q;
  pack_t pk_q;
  pack_t out_q;
  logic [15:0] crc_q;

  assign out_ready     = !mv_q || m_axis_tready;
  assign pk_ready      = !pv_q || out_ready;
  assign s_axis_tready = pk_ready;
  assign s_fire        = s_axis_tvalid && pk_ready;

  // per-item pack update and pack completion
  always_comb begin
    terms     = term_q[1] ? 2'd2 : 2'd1;
    nbytes    = {1'b0, in_has} + (in_eof ? terms : 2'd0);
    fill_eff  = open_q ? fill_q : '0;
    cur_type  = open_q ? type_q : {TYPE_BASE, in_type};
    cur_track = open_q ? track_q : in_track;
    cur_pos   = open_q ? pos_q : fpos_q;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      cur_store[i] = open_q ? store_q[i] : 8'h00;
    end
    if (in_has) begin
      cur_store[fill_eff] = in_data;
    end
    fill_sum = {1'b0, fill_eff} + {{(FILL_W - 1){1'b0}}, nbytes};
    left     = FILL_W'(fill_sum - (FILL_W + 1)'(PAYLOAD_BYTES));
    seq_base = in_nb ? 8'd0 : seq_q;

    emit    = 1'b0;
    open_d  = open_q;
    fill_d  = fill_q;
    type_d  = type_q;
    track_d = track_q;
    pos_d   = pos_q;
    seq_d   = seq_q;
    fpos_d  = fpos_q;
    store_d = store_q;
    pk_d    = '0;

    if (in_flush) begin
      // close an open partial pack, zero padded
      if (open_q) begin
        emit         = 1'b1;
        pk_d.ptype   = type_q;
        pk_d.track   = track_q;
        pk_d.seq     = seq_q;
        pk_d.blk_pos = {1'b0, blk_q, pos_q};
        for (int i = 0; i < HALF_BYTES; i++) begin
          pk_d.pay_hi[HALF_W-1-8*i -: 8] = store_q[i];
          pk_d.pay_lo[HALF_W-1-8*i -: 8] = store_q[i + HALF_BYTES];
        end
        seq_d  = seq_q + 8'd1;
        open_d = 1'b0;
        fill_d = '0;
      end
    end else begin
      fpos_d = in_eof ? 4'd0 : fpos_q + {3'b000, in_has};
      if (fill_sum >= (FILL_W + 1)'(PAYLOAD_BYTES)) begin
        // pack fills up; trailing terminators open a fresh pack
        emit         = 1'b1;
        pk_d.ptype   = cur_type;
        pk_d.track   = cur_track;
        pk_d.seq     = seq_base;
        pk_d.blk_pos = {1'b0, blk_q, cur_pos};
        for (int i = 0; i < HALF_BYTES; i++) begin
          pk_d.pay_hi[HALF_W-1-8*i -: 8] = cur_store[i];
          pk_d.pay_lo[HALF_W-1-8*i -: 8] = cur_store[i + HALF_BYTES];
        end
        seq_d = seq_base + 8'd1;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          store_d[i] = 8'h00;
        end
        open_d  = (left != '0);
        fill_d  = left;
        type_d  = {TYPE_BASE, in_type};
        track_d = in_track;
        pos_d   = fpos_q + (4'(PAYLOAD_BYTES) - 4'(fill_eff));
      end else begin
        seq_d = seq_base;
        if (nbytes != 2'd0) begin
          open_d  = 1'b1;
          fill_d  = fill_sum[FILL_W-1:0];
          type_d  = cur_type;
          track_d = cur_track;
          pos_d   = cur_pos;
          store_d = cur_store;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      fill_q <= '0;
      seq_q  <= 8'd0;
      fpos_q <= 4'd0;
    end else if (s_fire) begin
      open_q <= open_d;
      fill_q <= fill_d;
      seq_q  <= seq_d;
      fpos_q <= fpos_d;
    end
  end

  // header and payload of the open pack
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      type_q  <= type_d;
      track_q <= track_d;
      pos_q   <= pos_d;
      store_q <= store_d;
    end
  end

  // pack register and output register valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      mv_q <= 1'b0;
    end else begin
      if (pk_ready) begin
        pv_q <= s_fire && emit;
      end
      if (out_ready) begin
        mv_q <= pv_q;
      end
    end
  end

  // pack and output data, crc on the way out
  always_ff @(posedge clk_i) begin
    if (pk_ready && s_fire && emit) begin
      pk_q <= pk_d;
    end
    if (out_ready && pv_q) begin
      out_q <= pk_q;
      crc_q <= pack_crc(pk_q);
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {1'b0, crc_q, out_q.pay_lo, out_q.pay_hi, out_q.blk_pos,
                          out_q.seq, out_q.track, out_q.ptype};

  // checks
  `CDTPF_ASSERT(a_fill_range, fill_q < FILL_W'(PAYLOAD_BYTES), "fill count beyond payload")
  `CDTPF_ASSERT(a_open_fill, open_q == (fill_q != '0), "open flag and fill count disagree")
  `CDTPF_ASSERT_NEXT(a_pk_hold, pv_q && !out_ready, pv_q && $stable(pk_q), "stalled pack lost")

endmodule

`default_nettype wire

/* dv/cd_text_pack_framer_unit_tb.sv */
// ----------------------------------------------------------------------------
// cd_text_pack_framer_unit_tb
// self-checking bench for the cd-text pack framer
// ----------------------------------------------------------------------------
// Text byte transactions go in on s_axis from a queue of pending items, with
// random gaps. Packs come out on m_axis under random back-pressure. Every
// accepted input transaction runs through a local pack-building model (fill,
// terminators, header, crc-16 ccitt with zero preset). Each pack that model
// closes is queued, and every m_axis transaction is checked field by field
// against the oldest queued pack. A directed opening covers the edge cases.
// Random phases follow, each with its own terminator count and block number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_text_pack_framer_unit_tb;

  import cdtpf_pkg::*;

  // one input item before packing onto the stream
  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       eof;
    logic [6:0] track;
    logic [3:0] tcode;
    logic       flush;
    logic       nblk;
  } text_item_t;

  // one finished pack as the model builds it
  typedef struct {
    logic [7:0]  ptype;
    logic [6:0]  track;
    logic [7:0]  seq;
    logic [7:0]  blk_pos;
    logic [47:0] pay_hi;
    logic [47:0] pay_lo;
    logic [15:0] crc;
  } framed_pack_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic [S_USER_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  cd_text_pack_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // pending input items and packs still owed by the block
  text_item_t   text_items_q[$];
  framed_pack_t owed_packs_q[$];
  int           n_errors = 0;
  bit           in_taken = 1'b0;
  int           in_gap = 0;
  bit           in_calm = 1'b0;
  int           out_stall = 0;
  bit           out_calm = 1'b0;

  // model state
  logic [7:0] pay_buf [PAYLOAD_BYTES];
  int         fill_cnt = 0;
  bit         pk_open = 1'b0;
  logic [7:0] open_ptype = '0;
  logic [6:0] open_track = '0;
  logic [3:0] open_pos = '0;
  logic [7:0] seq_cnt = '0;
  logic [3:0] fld_pos = '0;
  logic [1:0] term_cfg = 2'd1;
  logic [2:0] block_cfg = 3'd0;

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // crc-16 ccitt, one byte msb first
  function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  // close the open pack and queue it as owed
  function automatic void close_pack();
    framed_pack_t p;
    logic [15:0]  c;
    p.ptype   = open_ptype;
    p.track   = open_track;
    p.seq     = seq_cnt;
    p.blk_pos = {1'b0, block_cfg, open_pos};
    p.pay_hi  = '0;
    p.pay_lo  = '0;
    c = crc_ccitt_byte(16'h0000, p.ptype);
    c = crc_ccitt_byte(c, {1'b0, p.track});
    c = crc_ccitt_byte(c, p.seq);
    c = crc_ccitt_byte(c, p.blk_pos);
    for (int i = 0; i < PAYLOAD_BYTES; i++)
      c = crc_ccitt_byte(c, pay_buf[i]);
    for (int i = 0; i < 6; i++) begin
      p.pay_hi = {p.pay_hi[39:0], pay_buf[i]};
      p.pay_lo = {p.pay_lo[39:0], pay_buf[i + 6]};
    end
    p.crc = c;
    owed_packs_q.push_back(p);
    seq_cnt  = seq_cnt + 8'd1;
    pk_open  = 1'b0;
    fill_cnt = 0;
  endfunction

  // add one byte, opening a pack first if none is open
  function automatic void append_byte(logic [7:0] b, logic [7:0] pt, logic [6:0] tr);
    if (!pk_open) begin
      foreach (pay_buf[i]) pay_buf[i] = 8'h00;
      fill_cnt   = 0;
      open_ptype = pt;
      open_track = tr;
      open_pos   = fld_pos;
      pk_open    = 1'b1;
    end
    pay_buf[fill_cnt] = b;
    fill_cnt++;
    fld_pos = fld_pos + 4'd1;
    if (fill_cnt >= PAYLOAD_BYTES) close_pack();
  endfunction

  // model of one accepted input transaction
  function automatic void frame_text_item(text_item_t it);
    logic [7:0] pt;
    int         nterm;
    pt = {TYPE_BASE, it.tcode};
    if (it.flush) begin
      if (pk_open) close_pack();
      return;
    end
    if (it.nblk) seq_cnt = '0;
    if (it.has) append_byte(it.data, pt, it.track);
    if (it.eof) begin
      nterm = (term_cfg == 2'd0) ? 1 : (term_cfg == 2'd3) ? 2 : int'(term_cfg);
      for (int t = 0; t < nterm; t++) append_byte(8'h00, pt, it.track);
      fld_pos = '0;
    end
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      n_errors++;
    end
  endfunction

  // compare one output transaction with the oldest owed pack
  function automatic void check_pack(logic [M_DATA_W-1:0] d);
    framed_pack_t p;
    if (owed_packs_q.size() == 0) begin
      $display("%0t ns: unexpected pack, expected none, actual %h", $time, d);
      n_errors++;
      return;
    end
    p = owed_packs_q.pop_front();
    check_field("pack_type", p.ptype, d[7:0]);
    check_field("pack_track", p.track, d[14:8]);
    check_field("sequence_res", p.seq, d[22:15]);
    check_field("block_and_position", p.blk_pos, d[30:23]);
    check_field("payload_high", p.pay_hi, d[78:31]);
    check_field("payload_low", p.pay_lo, d[126:79]);
    check_field("check_word", p.crc, d[142:127]);
  endfunction

  // sample handshakes, check packs, run the model
  always @(posedge clk_i) begin : watch_ports
    text_item_t it;
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TERM) term_cfg = cfg_data_i[1:0];
        else if (cfg_index_i == CFG_BLOCK) block_cfg = cfg_data_i[2:0];
      end
      if (m_axis_tvalid && m_axis_tready) check_pack(m_axis_tdata);
      if (in_taken) begin
        it.data  = s_axis_tdata[7:0];
        it.track = s_axis_tdata[14:8];
        it.eof   = s_axis_tlast;
        it.has   = s_axis_tuser[0];
        it.tcode = s_axis_tuser[4:1];
        it.flush = s_axis_tuser[5];
        it.nblk  = s_axis_tuser[6];
        frame_text_item(it);
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // input driver, fed from the pending item queue
  always @(negedge clk_i) begin : feed_items
    text_item_t it;
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (text_items_q.size() > 0) begin
        it = text_items_q.pop_front();
        s_axis_tdata  <= {1'b0, it.track, it.data};
        s_axis_tlast  <= it.eof;
        s_axis_tuser  <= {it.nblk, it.flush, it.tcode, it.has};
        s_axis_tvalid <= 1'b1;
        in_gap = in_calm ? 0 : gap_len();
        if ($urandom_range(0, 79) == 0) in_calm = !in_calm;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin : stall_output
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) out_stall = gap_len();
      if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
    end
  end

  function automatic void queue_item(logic [7:0] data, logic has, logic eof,
                                     logic [6:0] track, logic [3:0] tcode,
                                     logic flush, logic nblk);
    text_item_t it;
    it.data  = data;
    it.has   = has;
    it.eof   = eof;
    it.track = track;
    it.tcode = tcode;
    it.flush = flush;
    it.nblk  = nblk;
    text_items_q.push_back(it);
  endfunction

  function automatic logic [6:0] rand_track();
    return ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, 99));
  endfunction

  // random stimulus: mostly whole fields, some markers, flushes and noise
  function automatic void queue_random(int n_items);
    int         made;
    int         r;
    int         len;
    logic [6:0] tr;
    logic [3:0] tc;
    logic       nb;
    made = 0;
    while (made < n_items) begin
      r  = $urandom_range(0, 99);
      tr = rand_track();
      tc = 4'($urandom_range(0, 15));
      if (r < 75) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
        nb  = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < len; i++)
          queue_item(8'($urandom_range(0, 255)), 1'b1, i == len - 1, tr, tc, 1'b0,
                     nb && i == 0);
        made += len;
        if ($urandom_range(0, 5) == 0) begin
          queue_item(8'($urandom), 1'b0, 1'($urandom), tr, tc, 1'b1, 1'($urandom));
          made++;
        end
      end else if (r < 82) begin
        // empty field marker
        queue_item(8'($urandom), 1'b0, 1'b1, tr, tc, 1'b0, 1'($urandom_range(0, 9) == 0));
        made++;
      end else if (r < 88) begin
        queue_item(8'($urandom), 1'($urandom), 1'($urandom), tr, tc, 1'b1, 1'($urandom));
        made++;
      end else if (r < 94) begin
        // unconstrained item
        queue_item(8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom), tc,
                   1'($urandom), 1'($urandom));
        if (text_items_q[$].has || text_items_q[$].eof || text_items_q[$].flush ||
            text_items_q[$].nblk)
          made++;
      end else begin
        // field cut short without its end
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, tr, tc, 1'b0, 1'b0);
        made += len;
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every item is taken and every pack has come out
  task automatic drain_all();
    while (text_items_q.size() != 0 || s_axis_tvalid || owed_packs_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // main sequence
  initial begin : run_test
    logic [1:0] term_set [6];
    logic [2:0] block_set [6];
    term_set  = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
    block_set = '{3'd7, 3'd0, 3'd3, 3'd5, 3'($urandom), 3'($urandom)};
    foreach (pay_buf[i]) pay_buf[i] = 8'h00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // flush with nothing open, new_block set on it
    queue_item(8'h5A, 1'b0, 1'b0, 7'd3, 4'h2, 1'b1, 1'b1);
    // no byte and no end
    queue_item(8'hC3, 1'b0, 1'b0, 7'd9, 4'h1, 1'b0, 1'b0);
    // field extremes
    queue_item(8'h00, 1'b1, 1'b0, 7'd0, 4'h0, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b1, 7'd127, 4'hF, 1'b0, 1'b0);
    // empty field marker
    queue_item(8'h00, 1'b0, 1'b1, 7'd99, 4'h7, 1'b0, 1'b0);
    // eleven-byte field, new_block on the first byte
    for (int i = 0; i < 11; i++)
      queue_item(8'($urandom_range(0, 255)), 1'b1, i == 10, 7'd42, 4'h5, 1'b0, i == 0);
    // new_block in the middle of a pack
    queue_item(8'h41, 1'b1, 1'b0, 7'd1, 4'h0, 1'b0, 1'b1);
    // flush with a pack open, new_block ignored
    queue_item(8'h42, 1'b1, 1'b0, 7'd1, 4'h0, 1'b1, 1'b1);
    // flush again, nothing open
    queue_item(8'h00, 1'b0, 1'b0, 7'd0, 4'h0, 1'b1, 1'b0);
    drain_all();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_TERM, {1'b0, term_set[p]});
      write_reg(CFG_BLOCK, block_set[p]);
      queue_random(150);
      drain_all();
    end

    if (owed_packs_q.size() != 0) begin
      $display("%0t ns: packs missing, expected %0d more, actual 0",
               $time, owed_packs_q.size());
      n_errors++;
    end
    if (n_errors == 0)
      $display("cd_text_pack_framer_unit_tb: PASS");
    else
      $display("cd_text_pack_framer_unit_tb: FAIL");
    $finish;
  end

  // run limit
  initial begin : run_limit
    #10_000_000;
    $display("cd_text_pack_framer_unit_tb: FAIL");
    $finish;
  end

endmodule
